### hw/rtl/source_text_tokenizer_assert.svh
// assertion macros shared by the tokenizer rtl
// expects signals named clk and arst_n in the including module
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// same-cycle implication, off during reset
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/stt_pkg.sv
// shared types, character codes and keyword patterns for the tokenizer
// no dependencies
package stt_pkg;

	localparam int TEXT_W = 64;
	localparam int LEN_W = 8;
	localparam int VALUE_W = 32;

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W = 2;
	localparam int CNT_W = 3;

	typedef enum logic [3:0] {
		KIND_EOF = 4'd0,
		KIND_LET = 4'd1,
		KIND_COLON = 4'd2,
		KIND_SEMI = 4'd3,
		KIND_I32 = 4'd4,
		KIND_IDENT = 4'd5,
		KIND_LIT = 4'd6,
		KIND_EQ = 4'd7,
		KIND_PLUS = 4'd8,
		KIND_OPEN = 4'd9,
		KIND_CLOSE = 4'd10,
		KIND_RETURN = 4'd11,
		KIND_UNKNOWN = 4'd12
	} kind_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_OPEN = 8'h7B;
	localparam logic [7:0] CH_CLOSE = 8'h7D;
	localparam logic [7:0] CH_ZERO = 8'h30;

	// keyword text, first character in the low byte
	localparam logic [TEXT_W-1:0] TEXT_LET = 64'h0000_0000_0074_656C;
	localparam logic [TEXT_W-1:0] TEXT_RETURN = 64'h0000_6E72_7574_6572;
	localparam logic [TEXT_W-1:0] TEXT_I32 = 64'h0000_0000_0032_3369;
	localparam logic [LEN_W-1:0] LEN_LET = 8'd3;
	localparam logic [LEN_W-1:0] LEN_RETURN = 8'd6;
	localparam logic [LEN_W-1:0] LEN_I32 = 8'd3;

	typedef struct packed {
		kind_t kind;
		logic [TEXT_W-1:0] text;
		logic [LEN_W-1:0] length;
		logic overlong;
		logic [VALUE_W-1:0] value;
		logic last;
	} result_t;

	// results produced by one scanner step, first goes out first
	typedef struct packed {
		logic [1:0] count;
		result_t first;
		result_t second;
	} push_t;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

endpackage

### hw/rtl/stt_in_if.sv
// valid/ready channel for source bytes
// no dependencies
interface stt_in_if;
	logic valid;
	logic ready;
	logic [7:0] byte_in;
	logic end_of_text;

	modport source (output valid, output byte_in, output end_of_text, input ready);
	modport sink (input valid, input byte_in, input end_of_text, output ready);
endinterface

### hw/rtl/stt_out_if.sv
// valid/ready channel for tokens
// no dependencies
interface stt_out_if;
	logic valid;
	logic ready;
	logic [3:0] token_kind;
	logic [63:0] token_text;
	logic [7:0] token_length;
	logic overlong;
	logic [31:0] literal_value;
	logic last_of_run;

	modport source (output valid, output token_kind, output token_text, output token_length,
		output overlong, output literal_value, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_text, input token_length,
		input overlong, input literal_value, input last_of_run, output ready);
endinterface

### hw/rtl/source_text_tokenizer.sv
// Source text tokenizer, top level.
// Channels: in_ch takes one source byte or an end mark (end_of_text) per
// transaction; out_ch gives one token per transaction with kind, first eight
// characters, saturated length, overlong flag and literal value. last_of_run
// marks the final token caused by an input transaction; one input gives zero,
// one or two tokens.
// Path: a token caused by an accepted byte passes the input register, then
// the scanner step into the queue, before it can be taken.
// Throughput: one input per cycle while each input gives at most one token
// and the receiver does not stall; the single output port sets the limit, so
// inputs giving two tokens are drained one token at a time.
// Stall: a four-entry result queue absorbs a stalled receiver; the scanner
// steps only while two entries are free, and the input register holds its
// byte until then, dropping in_ch.ready.
// Reset (arst_n low): no token open, queue empty, no output valid.
// depends on stt_pkg, stt_in_if, stt_out_if, stt_scan, stt_outq
module source_text_tokenizer #(
	parameter int MAX_TOKEN_LEN = 254
) (
	input logic clk,
	input logic arst_n,
	stt_in_if.sink in_ch,
	stt_out_if.source out_ch
);
	import stt_pkg::*;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic eot_s1;
	logic room, advance, head_valid;
	push_t push;
	result_t head;

	assign advance = valid_s1 && room;
	assign in_ch.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.byte_in;
			eot_s1 <= in_ch.end_of_text;
		end
	end

	stt_scan #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.byte_in(byte_s1),
		.end_of_text(eot_s1),
		.push(push)
	);

	stt_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.head_valid(head_valid),
		.head(head),
		.head_ready(out_ch.ready)
	);

	// output channel
	assign out_ch.valid = head_valid;
	assign out_ch.token_kind = head.kind;
	assign out_ch.token_text = head.text;
	assign out_ch.token_length = head.length;
	assign out_ch.overlong = head.overlong;
	assign out_ch.literal_value = head.value;
	assign out_ch.last_of_run = head.last;

endmodule

### hw/rtl/stt_scan.sv
// scanner core: token state registers and the per-byte step logic
// depends on stt_pkg
module stt_scan #(
	parameter int MAX_TOKEN_LEN = 254
) (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] byte_in,
	input logic end_of_text,
	output stt_pkg::push_t push
);
	import stt_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WORD = 2'd1,
		MODE_WDIG = 2'd2,
		MODE_LIT = 2'd3
	} mode_t;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN_LEN);

	mode_t mode_q, mode_d;
	logic [TEXT_W-1:0] prefix_q, prefix_d;
	logic [LEN_W-1:0] count_q, count_d;
	logic ovf_q, ovf_d;
	logic [VALUE_W-1:0] acc_q, acc_d;

	logic letter, digit, space;
	logic extend, has_pend, has_single;
	logic [VALUE_W-1:0] digit_val;
	kind_t pend_kind, byte_kind;
	result_t pend_res, single_res;

	// byte classes
	always_comb begin
		letter = is_letter(byte_in);
		digit = is_digit(byte_in);
		space = (byte_in == CH_SPACE) || (byte_in == CH_TAB) || (byte_in == CH_NL);
		digit_val = VALUE_W'(byte_in - CH_ZERO);
	end

	// kind of the open token, keywords matched on the whole word
	always_comb begin
		if (mode_q == MODE_LIT)
			pend_kind = KIND_LIT;
		else if (!ovf_q && count_q == LEN_LET && prefix_q == TEXT_LET)
			pend_kind = KIND_LET;
		else if (!ovf_q && count_q == LEN_RETURN && prefix_q == TEXT_RETURN)
			pend_kind = KIND_RETURN;
		else if (!ovf_q && count_q == LEN_I32 && prefix_q == TEXT_I32)
			pend_kind = KIND_I32;
		else
			pend_kind = KIND_IDENT;
	end

	// one-byte token kinds
	always_comb begin
		unique case (byte_in)
			CH_COLON: byte_kind = KIND_COLON;
			CH_SEMI: byte_kind = KIND_SEMI;
			CH_EQ: byte_kind = KIND_EQ;
			CH_PLUS: byte_kind = KIND_PLUS;
			CH_OPEN: byte_kind = KIND_OPEN;
			CH_CLOSE: byte_kind = KIND_CLOSE;
			default: byte_kind = KIND_UNKNOWN;
		endcase
	end

	// candidate results
	always_comb begin
		pend_res.kind = pend_kind;
		pend_res.text = prefix_q;
		pend_res.length = count_q;
		pend_res.overlong = ovf_q;
		pend_res.value = (mode_q == MODE_LIT) ? acc_q : '0;
		pend_res.last = 1'b0;

		if (end_of_text) begin
			single_res.kind = KIND_EOF;
			single_res.text = '0;
			single_res.length = '0;
		end else begin
			single_res.kind = byte_kind;
			single_res.text = TEXT_W'(byte_in);
			single_res.length = LEN_W'(1);
		end
		single_res.overlong = 1'b0;
		single_res.value = '0;
		single_res.last = 1'b0;
	end

	// step decision, next state and result bundle
	always_comb begin
		extend = !end_of_text && (((mode_q == MODE_WORD) && (letter || digit)) ||
			((mode_q == MODE_WDIG) && digit) || ((mode_q == MODE_LIT) && digit));
		has_pend = (mode_q != MODE_IDLE);
		has_single = end_of_text || !(space || letter || digit);

		mode_d = MODE_IDLE;
		prefix_d = '0;
		count_d = '0;
		ovf_d = 1'b0;
		acc_d = '0;
		push = '0;

		if (extend) begin
			// append to the open token
			mode_d = (mode_q == MODE_WORD && digit) ? MODE_WDIG : mode_q;
			prefix_d = prefix_q;
			if (count_q < LEN_W'(8))
				prefix_d[{count_q[2:0], 3'b000} +: 8] = byte_in;
			count_d = (count_q < MAX_LEN) ? count_q + LEN_W'(1) : count_q;
			ovf_d = ovf_q || (count_q >= MAX_LEN);
			acc_d = (mode_q == MODE_LIT) ?
				(acc_q << 3) + (acc_q << 1) + digit_val : acc_q;
		end else begin
			// close any open token, then handle the byte on its own
			if (!end_of_text && (letter || digit)) begin
				mode_d = letter ? MODE_WORD : MODE_LIT;
				prefix_d = TEXT_W'(byte_in);
				count_d = LEN_W'(1);
				acc_d = digit ? digit_val : '0;
			end
			if (has_pend && has_single) begin
				push.count = 2'd2;
				push.first = pend_res;
				push.second = single_res;
				push.second.last = 1'b1;
			end else if (has_pend || has_single) begin
				push.count = 2'd1;
				push.first = has_pend ? pend_res : single_res;
				push.first.last = 1'b1;
			end
		end

		if (!step)
			push.count = 2'd0;
	end

	// token state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			prefix_q <= '0;
			count_q <= '0;
			ovf_q <= 1'b0;
			acc_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			prefix_q <= prefix_d;
			count_q <= count_d;
			ovf_q <= ovf_d;
			acc_q <= acc_d;
		end
	end

endmodule

### hw/rtl/stt_outq.sv
// four-entry result queue, takes up to two results per cycle, gives one
// depends on stt_pkg and source_text_tokenizer_assert.svh
`include "source_text_tokenizer_assert.svh"

module stt_outq (
	input logic clk,
	input logic arst_n,
	input stt_pkg::push_t push,
	output logic room,
	output logic head_valid,
	output stt_pkg::result_t head,
	input logic head_ready
);
	import stt_pkg::*;

	result_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic pop;

	// head of queue and space for a full step
	always_comb begin
		head_valid = (count_q != '0);
		head = entry_q[rd_ptr_q];
		pop = head_valid && head_ready;
		room = (count_q <= CNT_W'(QUEUE_DEPTH - 2));
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			entry_q[wr_ptr_q] <= push.first;
		if (push.count == 2'd2)
			entry_q[wr_ptr_q + PTR_W'(1)] <= push.second;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	`STT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
	`STT_ASSERT_NOW(a_push_room, push.count != 2'd0, count_q <= CNT_W'(QUEUE_DEPTH - 2), "push without room")
	`STT_ASSERT_NEXT(a_pop_only, pop && push.count == 2'd0, count_q == $past(count_q) - CNT_W'(1), "pop count slip")

endmodule
